### hdl/cq_pkg.sv
// Shared widths, operation and status codes, and the result beat type of the circular queue.
package cq_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int KIND_W    = 3;
  localparam int DATA_W    = 32;
  localparam int STAT_W    = 2;
  localparam int CNT_W     = 6;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_ENQ  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DEQ  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLR  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TRAV = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] data;
    logic [CNT_W-1:0]         count;
    logic                     last;
  } out_beat_t;

  function automatic out_beat_t mk_beat(input logic [STAT_W-1:0] status,
                                        input logic signed [DATA_W-1:0] data,
                                        input logic [CNT_W-1:0] count,
                                        input logic last);
    out_beat_t b;
    b.status = status;
    b.data   = data;
    b.count  = count;
    b.last   = last;
    return b;
  endfunction

endpackage

### hdl/cq_if.sv
// Valid/ready channel interfaces for the queue's operation input and result output.
interface cq_in_if import cq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface cq_out_if import cq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] data;
  logic [CNT_W-1:0]         count;
  logic                     last;

  modport source (output valid, output status, output data, output count, output last,
                  input ready);
  modport sink   (input valid, input status, input data, input count, input last,
                  output ready);
endinterface

### hdl/circular_queue.sv
// Circular queue top level: pointer control, read sequencer and result register.
//
// A ring-buffer FIFO of signed 32-bit words with DEPTH slots; one slot stays
// free, so at most DEPTH-1 words are held. Operations arrive on in_ch
// (kind, value) and each beat produces results on out_ch (status, data,
// count, last); undefined kinds are taken and give no result.
// Enqueue, clear and any refused or empty operation finish in the accept
// cycle: result valid in the next cycle, next beat taken every cycle while
// the result register drains. Dequeue and peek read the storage RAM
// (registered read data) and take no new beat until the read returns.
// Traverse reads one word per cycle through the same RAM port while the
// receiver takes results, and emits N results for N held words, last on
// the final one; no input is taken until the traverse finishes.
// A result register sits on out_ch; a new beat is taken while a result
// waits if out_ready drains it in the same cycle. When the receiver stalls
// the result holds and a traverse pauses on the word it has read.
// Synchronous reset empties the queue (both pointers zero) and drops any
// pending result; storage contents are not cleared.
module circular_queue import cq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  cq_in_if.sink     in_ch,
  cq_out_if.source  out_ch
);

  localparam int AW = $clog2(DEPTH);
  localparam int HW = AW + 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [HW-1:0] DEPTH_H  = HW'(DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RD   = 3'b010,
    ST_TRAV = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [AW-1:0]     tail_r, tail_nxt;
  logic [AW-1:0]     trv_ptr_r, trv_ptr_nxt;
  logic [CNT_W-1:0]  pend_cnt_r, pend_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_beat_t         out_beat_r, out_beat_nxt;

  logic              in_acc;
  logic              out_free;
  logic              empty;
  logic              full;
  logic [AW-1:0]     tail_adv;
  logic [AW-1:0]     trv_adv;
  logic              trv_last;
  logic [HW-1:0]     held_now;

  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + AW'(1);
  endfunction

  cq_mem #(.DEPTH(DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (tail_r),
    .wdata ($unsigned(in_ch.value)),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // handshake and occupancy
  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && out_free;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign empty       = (head_r == tail_r);
  assign tail_adv    = adv(tail_r);
  assign full        = (tail_adv == head_r);
  assign trv_adv     = adv(trv_ptr_r);
  assign trv_last    = (trv_adv == tail_r);
  assign held_now    = (tail_r >= head_r) ? ({1'b0, tail_r} - {1'b0, head_r})
                                          : ({1'b0, tail_r} + DEPTH_H - {1'b0, head_r});

  // operation sequencer
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    trv_ptr_nxt   = trv_ptr_r;
    pend_cnt_nxt  = pend_cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_beat_nxt  = out_beat_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_raddr     = head_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_ch.kind)
            KIND_ENQ: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_beat_nxt = mk_beat(STAT_FULL, '0, CNT_W'(held_now), 1'b1);
              end else begin
                mem_we       = 1'b1;
                tail_nxt     = tail_adv;
                out_beat_nxt = mk_beat(STAT_OK, '0, CNT_W'(held_now + HW'(1)), 1'b1);
              end
            end
            KIND_DEQ: begin
              if (empty) begin
                out_valid_nxt = 1'b1;
                out_beat_nxt  = mk_beat(STAT_EMPTY, '0, '0, 1'b1);
              end else begin
                mem_re       = 1'b1;
                head_nxt     = adv(head_r);
                pend_cnt_nxt = CNT_W'(held_now - HW'(1));
                state_nxt    = ST_RD;
              end
            end
            KIND_PEEK: begin
              if (empty) begin
                out_valid_nxt = 1'b1;
                out_beat_nxt  = mk_beat(STAT_EMPTY, '0, '0, 1'b1);
              end else begin
                mem_re       = 1'b1;
                pend_cnt_nxt = CNT_W'(held_now);
                state_nxt    = ST_RD;
              end
            end
            KIND_CLR: begin
              head_nxt      = '0;
              tail_nxt      = '0;
              out_valid_nxt = 1'b1;
              out_beat_nxt  = mk_beat(STAT_OK, '0, '0, 1'b1);
            end
            KIND_TRAV: begin
              if (empty) begin
                out_valid_nxt = 1'b1;
                out_beat_nxt  = mk_beat(STAT_EMPTY, '0, '0, 1'b1);
              end else begin
                mem_re       = 1'b1;
                trv_ptr_nxt  = head_r;
                pend_cnt_nxt = CNT_W'(held_now);
                state_nxt    = ST_TRAV;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RD: begin
        // result register is always free here; the check keeps it safe
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_beat_nxt  = mk_beat(STAT_OK, $signed(mem_rdata), pend_cnt_r, 1'b1);
          state_nxt     = ST_IDLE;
        end
      end
      ST_TRAV: begin
        // emit the word in hand, fetch the next one
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_beat_nxt  = mk_beat(STAT_OK, $signed(mem_rdata), pend_cnt_r, trv_last);
          if (trv_last) begin
            state_nxt = ST_IDLE;
          end else begin
            mem_re      = 1'b1;
            mem_raddr   = trv_adv;
            trv_ptr_nxt = trv_adv;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    trv_ptr_r  <= trv_ptr_nxt;
    pend_cnt_r <= pend_cnt_nxt;
    out_beat_r <= out_beat_nxt;
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_beat_r.status;
  assign out_ch.data   = out_beat_r.data;
  assign out_ch.count  = out_beat_r.count;
  assign out_ch.last   = out_beat_r.last;

  // pointers stay inside the ring
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r <= LAST_IDX) && (tail_r <= LAST_IDX))
    else $error("queue pointer outside the ring");

  // an accepted enqueue into a non-full queue moves the tail
  a_enq_moves_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_ch.kind == KIND_ENQ) && !full) |=> (tail_r != $past(tail_r)))
    else $error("enqueue did not advance tail");

  // the queue is frozen while a traverse runs
  a_trav_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TRAV) |=> ($stable(head_r) && $stable(tail_r)))
    else $error("pointers changed during traverse");

  // the final traverse beat returns the sequencer to idle
  a_trav_done: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_TRAV) && out_free && trv_last) |=> (state_r == ST_IDLE))
    else $error("traverse did not finish on its last word");

endmodule

### hdl/cq_mem.sv
// Word storage of the ring: one write port, one read port with registered read data.
module cq_mem import cq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [DATA_W-1:0]          wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [DATA_W-1:0]          rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port; data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### dv/tb_top.sv
// Self-checking testbench for the circular queue: directed table, random op mix, ring predictor.
module tb_top;
  import cq_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int N_DIR = 24;

  // kind codes the block takes and drops without a result
  localparam logic [KIND_W-1:0] KIND_RSV5 = 3'd5;
  localparam logic [KIND_W-1:0] KIND_RSV6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_RSV7 = 3'd7;

  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] value;
    logic                     typed;  // 1: use the beat below instead of the predictor
    out_beat_t                want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  cq_in_if  in_ch ();
  cq_out_if out_ch ();

  circular_queue #(.DEPTH(DEPTH)) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run-wide knobs and bookkeeping
  bit        gaps_in;
  bit        stalls_out;
  int        fails;
  int        ops_taken;
  int        ops_ignored;
  int        beats_checked;
  int        fills_refused;
  int        trav_beats;
  int        peak_fill;

  // predictor state: ring contents and pointers
  logic signed [DATA_W-1:0] ring_mem [DEPTH];
  int                       hd;
  int                       tl;
  out_beat_t                beats_due[$];

  // directed table: empty cases, word extremes, reserved kinds, clear, wraparound-free basics
  dir_row_t plan [N_DIR] = '{
    '{KIND_DEQ,  32'sd0,          1'b1, '{STAT_EMPTY, 32'sd0,   6'd0, 1'b1}},
    '{KIND_PEEK, 32'sd0,          1'b1, '{STAT_EMPTY, 32'sd0,   6'd0, 1'b1}},
    '{KIND_TRAV, 32'sd0,          1'b1, '{STAT_EMPTY, 32'sd0,   6'd0, 1'b1}},
    '{KIND_ENQ,  WORD_MAX,        1'b1, '{STAT_OK,    32'sd0,   6'd1, 1'b1}},
    '{KIND_ENQ,  WORD_MIN,        1'b1, '{STAT_OK,    32'sd0,   6'd2, 1'b1}},
    '{KIND_ENQ,  32'sd0,          1'b1, '{STAT_OK,    32'sd0,   6'd3, 1'b1}},
    '{KIND_ENQ,  -32'sd1,         1'b1, '{STAT_OK,    32'sd0,   6'd4, 1'b1}},
    '{KIND_PEEK, 32'sd0,          1'b1, '{STAT_OK,    WORD_MAX, 6'd4, 1'b1}},
    '{KIND_TRAV, 32'sd0,          1'b0, '0},
    '{KIND_RSV5, 32'sh5555_5555,  1'b0, '0},
    '{KIND_RSV6, 32'sh2aaa_aaaa,  1'b0, '0},
    '{KIND_RSV7, -32'sd1,         1'b0, '0},
    '{KIND_DEQ,  32'sd0,          1'b1, '{STAT_OK,    WORD_MAX, 6'd3, 1'b1}},
    '{KIND_DEQ,  32'sd0,          1'b0, '0},
    '{KIND_ENQ,  32'sh5a5a_5a5a,  1'b0, '0},
    '{KIND_TRAV, 32'sd0,          1'b0, '0},
    '{KIND_CLR,  32'sd0,          1'b1, '{STAT_OK,    32'sd0,   6'd0, 1'b1}},
    '{KIND_TRAV, 32'sd0,          1'b1, '{STAT_EMPTY, 32'sd0,   6'd0, 1'b1}},
    '{KIND_DEQ,  32'sd0,          1'b1, '{STAT_EMPTY, 32'sd0,   6'd0, 1'b1}},
    '{KIND_ENQ,  32'sha5a5_a5a5,  1'b1, '{STAT_OK,    32'sd0,   6'd1, 1'b1}},
    '{KIND_DEQ,  32'sd0,          1'b1, '{STAT_OK,    32'sha5a5_a5a5, 6'd0, 1'b1}},
    '{KIND_CLR,  -32'sd1,         1'b1, '{STAT_OK,    32'sd0,   6'd0, 1'b1}},
    '{KIND_ENQ,  32'sd1,          1'b0, '0},
    '{KIND_TRAV, 32'sd0,          1'b0, '0}
  };

  // queue one expected result beat
  function automatic void owe_beat(input logic [STAT_W-1:0] status,
                                   input logic signed [DATA_W-1:0] data,
                                   input int used, input logic last);
    out_beat_t b;
    b.status = status;
    b.data   = data;
    b.count  = CNT_W'(used);
    b.last   = last;
    beats_due.push_back(b);
  endfunction

  // ring predictor: apply one accepted op, optionally queue its result beats
  function automatic void ring_apply(input logic [KIND_W-1:0] kind,
                                     input logic signed [DATA_W-1:0] value,
                                     input bit emit);
    int used;
    int p;
    int nx;
    used = (tl + DEPTH - hd) % DEPTH;
    case (kind)
      KIND_ENQ: begin
        if ((tl + 1) % DEPTH == hd) begin
          fills_refused++;
          if (emit) owe_beat(STAT_FULL, '0, used, 1'b1);
        end else begin
          ring_mem[tl] = value;
          tl = (tl + 1) % DEPTH;
          if (used + 1 > peak_fill) peak_fill = used + 1;
          if (emit) owe_beat(STAT_OK, '0, used + 1, 1'b1);
        end
      end
      KIND_DEQ: begin
        if (used == 0) begin
          if (emit) owe_beat(STAT_EMPTY, '0, 0, 1'b1);
        end else begin
          p  = hd;
          hd = (hd + 1) % DEPTH;
          if (emit) owe_beat(STAT_OK, ring_mem[p], used - 1, 1'b1);
        end
      end
      KIND_PEEK: begin
        if (emit) begin
          if (used == 0) owe_beat(STAT_EMPTY, '0, 0, 1'b1);
          else           owe_beat(STAT_OK, ring_mem[hd], used, 1'b1);
        end
      end
      KIND_CLR: begin
        hd = 0;
        tl = 0;
        if (emit) owe_beat(STAT_OK, '0, 0, 1'b1);
      end
      KIND_TRAV: begin
        if (used == 0) begin
          if (emit) owe_beat(STAT_EMPTY, '0, 0, 1'b1);
        end else begin
          p = hd;
          while (p != tl) begin
            nx = (p + 1) % DEPTH;
            trav_beats++;
            if (emit) owe_beat(STAT_OK, ring_mem[p], used, nx == tl);
            p = nx;
          end
        end
      end
      default: ops_ignored++;
    endcase
  endfunction

  // random word, extremes now and then
  function automatic logic signed [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2:       return '0;
      default: return $urandom();
    endcase
  endfunction

  // drive one op beat; caller stands at a rising edge
  task automatic send_op(input logic [KIND_W-1:0] kind,
                         input logic signed [DATA_W-1:0] value,
                         input logic typed, input out_beat_t want);
    int gap;
    gap = gaps_in ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= kind;
    in_ch.value <= value;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    ops_taken++;
    ring_apply(kind, value, !typed);
    if (typed) beats_due.push_back(want);
  endtask

  // random op mix; n counts ops that are not dropped
  task automatic run_mix(input int n, input int enq_pct);
    int done;
    int r;
    logic [KIND_W-1:0] kind;
    done = 0;
    while (done < n) begin
      r = $urandom_range(0, 99);
      if (r < enq_pct)            kind = KIND_ENQ;
      else if (r < enq_pct + 25)  kind = KIND_DEQ;
      else if (r < enq_pct + 35)  kind = KIND_PEEK;
      else if (r < enq_pct + 41)  kind = KIND_TRAV;
      else if (r < enq_pct + 44)  kind = KIND_CLR;
      else                        kind = KIND_RSV5 + KIND_W'($urandom_range(0, 2));
      if (kind < KIND_RSV5) done++;
      send_op(kind, pick_word(), 1'b0, '0);
    end
  endtask

  // hold the input idle until every owed beat has come back
  task automatic drain_all();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (beats_due.size() != 0);
  endtask

  // result side: random backpressure, check each accepted beat
  initial begin : result_sink
    int stall;
    out_beat_t want;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = stalls_out ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      if (beats_due.size() == 0) begin
        $error("unexpected result beat: status %0d data %0d count %0d last %0d",
               out_ch.status, out_ch.data, out_ch.count, out_ch.last);
        fails++;
      end else begin
        want = beats_due.pop_front();
        beats_checked++;
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          fails++;
        end
        if (out_ch.data !== want.data) begin
          $error("data: expected %0d, got %0d", want.data, out_ch.data);
          fails++;
        end
        if (out_ch.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_ch.count);
          fails++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_ch.last);
          fails++;
        end
      end
    end
  end

  // stimulus
  initial begin : op_source
    int k;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.kind  <= KIND_ENQ;
    in_ch.value <= '0;
    hd = 0;
    tl = 0;
    gaps_in    = 1'b1;
    stalls_out = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (k = 0; k < N_DIR; k++)
      send_op(plan[k].kind, plan[k].value, plan[k].typed, plan[k].want);

    // general mix
    run_mix(30, 50);

    // let everything drain, then fill past full with no input gaps
    drain_all();
    gaps_in = 1'b0;
    send_op(KIND_CLR, pick_word(), 1'b0, '0);
    repeat (DEPTH + 5) send_op(KIND_ENQ, pick_word(), 1'b0, '0);
    stalls_out = 1'b0;
    send_op(KIND_TRAV, pick_word(), 1'b0, '0);
    send_op(KIND_PEEK, pick_word(), 1'b0, '0);

    // partial drain and refill so the pointers wrap
    gaps_in    = 1'b1;
    stalls_out = 1'b1;
    repeat (12) send_op(KIND_DEQ, pick_word(), 1'b0, '0);
    repeat (14) send_op(KIND_ENQ, pick_word(), 1'b0, '0);
    send_op(KIND_TRAV, pick_word(), 1'b0, '0);

    // blocks with differing idle settings and op balance
    gaps_in = 1'b0;
    run_mix(20, 60);
    gaps_in    = 1'b1;
    stalls_out = 1'b0;
    run_mix(20, 25);
    gaps_in    = $urandom_range(0, 1);
    stalls_out = 1'b1;
    run_mix(20, 45);

    drain_all();
    repeat (10) @(posedge clk);

    $display("Took %0d operations (%0d with reserved kinds); checked %0d result beats.",
             ops_taken, ops_ignored, beats_checked);
    $display("Peak fill %0d of %0d, %0d enqueues refused on full, %0d traversal beats.",
             peak_fill, DEPTH - 1, fills_refused, trav_beats);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #3000000;
    $display("FAIL");
    $finish;
  end

endmodule
